### sv/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types, constants and character helpers for the stream token scanner.
// ----------------------------------------------------------------------------
package sts_pkg;

  // Source size limit and the derived saturation point of the byte position
  localparam int MAX_SOURCE_BYTES = 65536;
  localparam int POS_LIMIT_INT    = (MAX_SOURCE_BYTES - 1 > 65535) ? 65535
                                                                   : MAX_SOURCE_BYTES - 1;
  localparam logic [15:0] POS_LIMIT  = 16'(POS_LIMIT_INT);
  localparam logic [15:0] LINE_LIMIT = 16'hFFFF;

  // Token queue depth
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Character codes
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;
  localparam logic [7:0] CH_LC_I   = 8'h69;
  localparam logic [7:0] CH_LC_R   = 8'h72;

  // Keyword match progress codes
  localparam logic [3:0] KW_NONE     = 4'd0;
  localparam logic [3:0] KW_I        = 4'd1;
  localparam logic [3:0] KW_INT_DONE = 4'd3;
  localparam logic [3:0] KW_R        = 4'd4;
  localparam logic [3:0] KW_RET_DONE = 4'd9;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_NUM  = 2'd1,
    MODE_ID   = 2'd2
  } scan_mode_t;

  typedef enum logic [3:0] {
    TK_LPAREN = 4'd0,
    TK_RPAREN = 4'd1,
    TK_LBRACE = 4'd2,
    TK_RBRACE = 4'd3,
    TK_SEMI   = 4'd4,
    TK_EQUAL  = 4'd5,
    TK_PLUS   = 4'd6,
    TK_NUMBER = 4'd7,
    TK_IDENT  = 4'd8,
    TK_INT    = 4'd9,
    TK_RETURN = 4'd10,
    TK_EOF    = 4'd11,
    TK_ERROR  = 4'd12
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [31:0] value;
    logic [7:0]  bad;
  } token_t;

  // All tokens caused by one accepted input transaction
  typedef struct packed {
    logic        has_a;  // flushed number or identifier
    token_t      tok_a;
    logic        has_b;  // punctuation, error or end of file
    token_t      tok_b;
    logic [15:0] line;
  } tok_rec_t;

  // Next character of the keyword text at a given progress index
  function automatic logic [7:0] kw_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd1:    ch = 8'h69;  // i
      4'd2:    ch = 8'h6E;  // n
      4'd3:    ch = 8'h74;  // t
      4'd4:    ch = 8'h72;  // r
      4'd5:    ch = 8'h65;  // e
      4'd6:    ch = 8'h74;  // t
      4'd7:    ch = 8'h75;  // u
      4'd8:    ch = 8'h72;  // r
      4'd9:    ch = 8'h6E;  // n
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= CH_LC_A) && (c <= CH_LC_Z)) ||
           ((c >= CH_UC_A) && (c <= CH_UC_Z)) || (c == CH_UNDER);
  endfunction

endpackage

### sv/sts_front.sv
// ----------------------------------------------------------------------------
// sts_front
// Scanner front end: classifies each byte, tracks the running scan state and
// builds one token record per transaction that produces any token.
// ----------------------------------------------------------------------------
module sts_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        char_code,
  input  logic              end_of_source,
  output logic              rec_push,
  output sts_pkg::tok_rec_t rec
);

  sts_pkg::scan_mode_t mode_r, mode_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] start_r, start_nxt;
  logic [15:0] line_r, line_nxt;
  logic [31:0] accum_r, accum_nxt;
  logic [3:0]  kw_r, kw_nxt;

  logic              flush_has;
  sts_pkg::token_t   flush_tok;
  logic [15:0]       pos_adv;
  logic [35:0]       accum_ext;
  logic [31:0]       accum_sat;
  logic [3:0]        kw_step;
  logic              num_cont;
  logic              id_cont;

  // Pending token as it would be flushed now
  always_comb begin
    flush_has       = (mode_r == sts_pkg::MODE_NUM) || (mode_r == sts_pkg::MODE_ID);
    flush_tok       = '0;
    flush_tok.start = start_r;
    flush_tok.len   = pos_r - start_r;
    if (mode_r == sts_pkg::MODE_NUM) begin
      flush_tok.kind  = sts_pkg::TK_NUMBER;
      flush_tok.value = accum_r;
    end else if (kw_r == sts_pkg::KW_INT_DONE) begin
      flush_tok.kind = sts_pkg::TK_INT;
    end else if (kw_r == sts_pkg::KW_RET_DONE) begin
      flush_tok.kind = sts_pkg::TK_RETURN;
    end else begin
      flush_tok.kind = sts_pkg::TK_IDENT;
    end
  end

  // Saturating position step, decimal step, keyword step and continuation checks
  always_comb begin
    pos_adv   = (pos_r < sts_pkg::POS_LIMIT) ? pos_r + 16'd1 : pos_r;
    accum_ext = {1'b0, accum_r, 3'b000} + {3'b000, accum_r, 1'b0}
              + {28'd0, char_code - sts_pkg::CH_ZERO};
    accum_sat = (accum_ext[35:32] != 4'd0) ? 32'hFFFF_FFFF : accum_ext[31:0];
    if ((kw_r != sts_pkg::KW_NONE) && (kw_r != sts_pkg::KW_INT_DONE) &&
        (kw_r < sts_pkg::KW_RET_DONE) && (sts_pkg::kw_char(kw_r + 4'd1) == char_code)) begin
      kw_step = kw_r + 4'd1;
    end else begin
      kw_step = sts_pkg::KW_NONE;
    end
    num_cont = (mode_r == sts_pkg::MODE_NUM) && sts_pkg::is_digit(char_code);
    id_cont  = (mode_r == sts_pkg::MODE_ID) &&
               (sts_pkg::is_alpha(char_code) || sts_pkg::is_digit(char_code));
  end

  // Next scan state
  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    line_nxt  = line_r;
    accum_nxt = accum_r;
    kw_nxt    = kw_r;
    if (accept) begin
      if (end_of_source) begin
        mode_nxt  = sts_pkg::MODE_IDLE;
        pos_nxt   = 16'd0;
        start_nxt = 16'd0;
        line_nxt  = 16'd1;
        accum_nxt = 32'd0;
        kw_nxt    = sts_pkg::KW_NONE;
      end else if (num_cont) begin
        accum_nxt = accum_sat;
        pos_nxt   = pos_adv;
      end else if (id_cont) begin
        kw_nxt  = kw_step;
        pos_nxt = pos_adv;
      end else begin
        start_nxt = pos_r;
        mode_nxt  = sts_pkg::MODE_IDLE;
        accum_nxt = 32'd0;
        kw_nxt    = sts_pkg::KW_NONE;
        pos_nxt   = pos_adv;
        if (char_code == sts_pkg::CH_NL) begin
          if (line_r < sts_pkg::LINE_LIMIT) line_nxt = line_r + 16'd1;
        end else if (sts_pkg::is_digit(char_code)) begin
          mode_nxt  = sts_pkg::MODE_NUM;
          accum_nxt = {24'd0, char_code - sts_pkg::CH_ZERO};
        end else if (sts_pkg::is_alpha(char_code)) begin
          mode_nxt = sts_pkg::MODE_ID;
          if (char_code == sts_pkg::CH_LC_I) kw_nxt = sts_pkg::KW_I;
          else if (char_code == sts_pkg::CH_LC_R) kw_nxt = sts_pkg::KW_R;
          else kw_nxt = sts_pkg::KW_NONE;
        end
      end
    end
  end

  // Token record of this transaction
  always_comb begin
    rec       = '0;
    rec.line  = line_r;
    rec.tok_a = flush_tok;
    if (accept && end_of_source) begin
      rec.has_a       = flush_has;
      rec.has_b       = 1'b1;
      rec.tok_b.kind  = sts_pkg::TK_EOF;
      rec.tok_b.start = pos_r;
    end else if (accept && !num_cont && !id_cont) begin
      rec.has_a       = flush_has;
      rec.tok_b.start = pos_r;
      rec.tok_b.len   = 16'd1;
      case (char_code)
        sts_pkg::CH_LPAREN: begin
          rec.has_b = 1'b1; rec.tok_b.kind = sts_pkg::TK_LPAREN;
        end
        sts_pkg::CH_RPAREN: begin
          rec.has_b = 1'b1; rec.tok_b.kind = sts_pkg::TK_RPAREN;
        end
        sts_pkg::CH_LBRACE: begin
          rec.has_b = 1'b1; rec.tok_b.kind = sts_pkg::TK_LBRACE;
        end
        sts_pkg::CH_RBRACE: begin
          rec.has_b = 1'b1; rec.tok_b.kind = sts_pkg::TK_RBRACE;
        end
        sts_pkg::CH_SEMI: begin
          rec.has_b = 1'b1; rec.tok_b.kind = sts_pkg::TK_SEMI;
        end
        sts_pkg::CH_EQUAL: begin
          rec.has_b = 1'b1; rec.tok_b.kind = sts_pkg::TK_EQUAL;
        end
        sts_pkg::CH_PLUS: begin
          rec.has_b = 1'b1; rec.tok_b.kind = sts_pkg::TK_PLUS;
        end
        sts_pkg::CH_SPACE, sts_pkg::CH_CR, sts_pkg::CH_TAB, sts_pkg::CH_NL: begin
        end
        default: begin
          if (!sts_pkg::is_digit(char_code) && !sts_pkg::is_alpha(char_code)) begin
            rec.has_b      = 1'b1;
            rec.tok_b.kind = sts_pkg::TK_ERROR;
            rec.tok_b.bad  = char_code;
          end
        end
      endcase
    end
    rec_push = rec.has_a || rec.has_b;
  end

  // Hold scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= sts_pkg::MODE_IDLE;
      pos_r   <= 16'd0;
      start_r <= 16'd0;
      line_r  <= 16'd1;
      accum_r <= 32'd0;
      kw_r    <= sts_pkg::KW_NONE;
    end else begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      line_r  <= line_nxt;
      accum_r <= accum_nxt;
      kw_r    <= kw_nxt;
    end
  end

endmodule

### sv/sts_queue.sv
// ----------------------------------------------------------------------------
// sts_queue
// Short queue of token records between the scanner front and the back end.
// ----------------------------------------------------------------------------
module sts_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sts_pkg::tok_rec_t push_rec,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output sts_pkg::tok_rec_t head_rec
);

  sts_pkg::tok_rec_t entry_r [sts_pkg::QDEPTH];
  logic [sts_pkg::QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [sts_pkg::QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [sts_pkg::QAW:0]   count_r, count_nxt;
  logic                    do_push, do_pop;

  assign full     = (count_r == (sts_pkg::QAW+1)'(sts_pkg::QDEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_rec = entry_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (sts_pkg::QAW+1)'(do_push) - (sts_pkg::QAW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store pushed record
  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_rec;
  end

endmodule

### sv/sts_back.sv
// ----------------------------------------------------------------------------
// sts_back
// Token back end: holds one record and delivers its tokens one per transaction.
// ----------------------------------------------------------------------------
module sts_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  sts_pkg::tok_rec_t q_rec,
  output logic              q_pop,
  input  logic              out_pop,
  output logic              out_empty,
  output sts_pkg::token_t   out_tok,
  output logic [15:0]       out_line,
  output logic              out_last
);

  sts_pkg::tok_rec_t rec_r, rec_nxt;
  logic              valid_r, valid_nxt;
  logic              phase_r, phase_nxt;
  logic              show_b, take, load;

  // Select the token on view
  always_comb begin
    show_b    = phase_r || !rec_r.has_a;
    out_last  = show_b || !rec_r.has_b;
    out_tok   = show_b ? rec_r.tok_b : rec_r.tok_a;
    out_line  = rec_r.line;
    out_empty = !valid_r;
  end

  // Advance through the record and refill from the queue
  always_comb begin
    take      = out_pop && valid_r;
    load      = !valid_r || (take && out_last);
    q_pop     = load && !q_empty;
    rec_nxt   = rec_r;
    valid_nxt = valid_r;
    phase_nxt = phase_r;
    if (load) begin
      rec_nxt   = q_rec;
      valid_nxt = !q_empty;
      phase_nxt = 1'b0;
    end else if (take) begin
      phase_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

endmodule

### sv/stream_token_scanner_top.sv
// ----------------------------------------------------------------------------
// stream_token_scanner_top
// Streaming maximal-munch token scanner: bytes in, tokens out, queue-style ports.
// ----------------------------------------------------------------------------
// Output: a token reaches the result ports once the transaction that completes it has
// been written into the queue and then loaded into the back stage.
// Throughput: one byte per cycle unless the queue is full; a two-token transaction
// is delivered as two pops from the back stage; the 4-record queue absorbs bursts.
// Reset: synchronous, active low; clears scan state (line 1, offset 0) and empties
// the queue and the output stage.
module stream_token_scanner_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_source,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [3:0]  out_token_kind,
  output logic [15:0] out_start_offset,
  output logic [15:0] out_token_length,
  output logic [15:0] out_line_number,
  output logic [31:0] out_number_value,
  output logic [7:0]  out_bad_char,
  output logic        out_last_of_run
);

  logic              accept;
  logic              rec_push;
  sts_pkg::tok_rec_t front_rec;
  sts_pkg::tok_rec_t head_rec;
  logic              q_empty, q_pop;
  sts_pkg::token_t   tok;

  assign accept = in_push && !in_full;

  sts_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .char_code     (in_char_code),
    .end_of_source (in_end_of_source),
    .rec_push      (rec_push),
    .rec           (front_rec)
  );

  sts_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (rec_push),
    .push_rec (front_rec),
    .full     (in_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_rec (head_rec)
  );

  sts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rec     (head_rec),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_tok   (tok),
    .out_line  (out_line_number),
    .out_last  (out_last_of_run)
  );

  // Unpack the token on view
  assign out_token_kind   = tok.kind;
  assign out_start_offset = tok.start;
  assign out_token_length = tok.len;
  assign out_number_value = tok.value;
  assign out_bad_char     = tok.bad;

endmodule

### tb/stream_token_scanner_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_token_scanner_top_tb
// Self-checking bench for the streaming token scanner. Source bytes and end
// markers go in through the push/full side. A local scanner model predicts the
// tokens of every accepted transaction, and a checker matches each popped
// token against the oldest prediction. Covered: punctuation, keywords, near
// keywords, numbers with overflow, errors, end markers mid-token, long
// receiver stalls and random idling on both sides.
// ----------------------------------------------------------------------------
module stream_token_scanner_top_tb;

  // Keyword text, byte k holds the character matched at progress k
  localparam logic [79:0] KW_TEXT = {"nruter", "tni", 8'h00};

  typedef struct packed {
    sts_pkg::tok_kind_t kind;
    logic [15:0]        start;
    logic [15:0]        len;
    logic [15:0]        line;
    logic [31:0]        value;
    logic [7:0]         bad;
    logic               last;
  } lex_tok_t;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [7:0]  in_char_code;
  logic        in_end_of_source;
  logic        out_empty;
  logic        out_pop;
  logic [3:0]  out_token_kind;
  logic [15:0] out_start_offset;
  logic [15:0] out_token_length;
  logic [15:0] out_line_number;
  logic [31:0] out_number_value;
  logic [7:0]  out_bad_char;
  logic        out_last_of_run;

  // Scanner model state
  sts_pkg::scan_mode_t mode;
  logic [15:0] pos;
  logic [15:0] tok_start;
  logic [15:0] line_cnt;
  logic [31:0] accum;
  logic [3:0]  kw_prog;
  lex_tok_t    held_tok;
  bit          held_valid;

  lex_tok_t    tokens_due[$];
  int          fail_count;
  int          items_sent;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          pop_hold_left;

  stream_token_scanner_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_char_code     (in_char_code),
    .in_end_of_source (in_end_of_source),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_token_kind   (out_token_kind),
    .out_start_offset (out_start_offset),
    .out_token_length (out_token_length),
    .out_line_number  (out_line_number),
    .out_number_value (out_number_value),
    .out_bad_char     (out_bad_char),
    .out_last_of_run  (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    #12_000_000;
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------- model

  function automatic bit is_dec(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic bit is_word(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  task automatic reset_state();
    mode     = sts_pkg::MODE_IDLE;
    pos      = 16'd0;
    tok_start = 16'd0;
    line_cnt = 16'd1;
    accum    = 32'd0;
    kw_prog  = sts_pkg::KW_NONE;
  endtask

  task automatic bump_pos();
    if (pos < sts_pkg::POS_LIMIT) pos = pos + 16'd1;
  endtask

  // Hold back one token so the last one of a transaction can be marked
  task automatic emit_tok(input sts_pkg::tok_kind_t k, input logic [15:0] st,
                          input logic [15:0] ln, input logic [31:0] val,
                          input logic [7:0] bad);
    if (held_valid) tokens_due = {tokens_due, held_tok};
    held_tok.kind  = k;
    held_tok.start = st;
    held_tok.len   = ln;
    held_tok.line  = line_cnt;
    held_tok.value = val;
    held_tok.bad   = bad;
    held_tok.last  = 1'b0;
    held_valid     = 1'b1;
  endtask

  task automatic commit_held();
    if (held_valid) begin
      held_tok.last = 1'b1;
      tokens_due    = {tokens_due, held_tok};
    end
    held_valid = 1'b0;
  endtask

  // Emit the pending number or word, then go idle
  task automatic flush_word();
    sts_pkg::tok_kind_t k;
    if (mode == sts_pkg::MODE_NUM) begin
      emit_tok(sts_pkg::TK_NUMBER, tok_start, pos - tok_start, accum, 8'd0);
    end else if (mode == sts_pkg::MODE_ID) begin
      k = sts_pkg::TK_IDENT;
      if (kw_prog == sts_pkg::KW_INT_DONE) k = sts_pkg::TK_INT;
      else if (kw_prog == sts_pkg::KW_RET_DONE) k = sts_pkg::TK_RETURN;
      emit_tok(k, tok_start, pos - tok_start, 32'd0, 8'd0);
    end
    mode    = sts_pkg::MODE_IDLE;
    accum   = 32'd0;
    kw_prog = sts_pkg::KW_NONE;
  endtask

  // Predict the tokens caused by one accepted transaction
  task automatic lex_step(input logic [7:0] ch, input logic eos);
    logic [35:0] wide;
    int          nxt;
    held_valid = 1'b0;
    if (eos) begin
      flush_word();
      emit_tok(sts_pkg::TK_EOF, pos, 16'd0, 32'd0, 8'd0);
      commit_held();
      reset_state();
      return;
    end
    if (mode == sts_pkg::MODE_NUM && is_dec(ch)) begin
      wide  = 36'(accum) * 36'd10 + 36'(ch - sts_pkg::CH_ZERO);
      accum = (wide > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
      bump_pos();
      return;
    end
    if (mode == sts_pkg::MODE_ID && (is_word(ch) || is_dec(ch))) begin
      nxt = int'(kw_prog) + 1;
      if (kw_prog != sts_pkg::KW_NONE && kw_prog != sts_pkg::KW_INT_DONE &&
          kw_prog < sts_pkg::KW_RET_DONE && KW_TEXT[8*nxt +: 8] == ch)
        kw_prog = kw_prog + 4'd1;
      else
        kw_prog = sts_pkg::KW_NONE;
      bump_pos();
      return;
    end
    flush_word();
    tok_start = pos;
    case (ch)
      sts_pkg::CH_LPAREN: emit_tok(sts_pkg::TK_LPAREN, tok_start, 16'd1, 32'd0, 8'd0);
      sts_pkg::CH_RPAREN: emit_tok(sts_pkg::TK_RPAREN, tok_start, 16'd1, 32'd0, 8'd0);
      sts_pkg::CH_LBRACE: emit_tok(sts_pkg::TK_LBRACE, tok_start, 16'd1, 32'd0, 8'd0);
      sts_pkg::CH_RBRACE: emit_tok(sts_pkg::TK_RBRACE, tok_start, 16'd1, 32'd0, 8'd0);
      sts_pkg::CH_SEMI:   emit_tok(sts_pkg::TK_SEMI, tok_start, 16'd1, 32'd0, 8'd0);
      sts_pkg::CH_EQUAL:  emit_tok(sts_pkg::TK_EQUAL, tok_start, 16'd1, 32'd0, 8'd0);
      sts_pkg::CH_PLUS:   emit_tok(sts_pkg::TK_PLUS, tok_start, 16'd1, 32'd0, 8'd0);
      sts_pkg::CH_SPACE, sts_pkg::CH_CR, sts_pkg::CH_TAB: ;
      sts_pkg::CH_NL: begin
        if (line_cnt < sts_pkg::LINE_LIMIT) line_cnt = line_cnt + 16'd1;
      end
      default: begin
        if (is_dec(ch)) begin
          mode  = sts_pkg::MODE_NUM;
          accum = 32'(ch - sts_pkg::CH_ZERO);
        end else if (is_word(ch)) begin
          mode    = sts_pkg::MODE_ID;
          kw_prog = (ch == sts_pkg::CH_LC_I) ? sts_pkg::KW_I :
                    (ch == sts_pkg::CH_LC_R) ? sts_pkg::KW_R : sts_pkg::KW_NONE;
        end else begin
          emit_tok(sts_pkg::TK_ERROR, tok_start, 16'd1, 32'd0, ch);
        end
      end
    endcase
    bump_pos();
    commit_held();
  endtask

  // ---------------------------------------------------------------- checker

  function automatic string tok_text(input lex_tok_t t);
    return $sformatf("kind=%0d start=%0d len=%0d line=%0d value=%0d bad=%02h last=%0b",
                     t.kind, t.start, t.len, t.line, t.value, t.bad, t.last);
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Match each popped token against the oldest prediction
  always @(posedge clk) begin : check_tokens
    lex_tok_t got;
    lex_tok_t want;
    if (rst_n && out_pop && !out_empty) begin
      got.kind  = sts_pkg::tok_kind_t'(out_token_kind);
      got.start = out_start_offset;
      got.len   = out_token_length;
      got.line  = out_line_number;
      got.value = out_number_value;
      got.bad   = out_bad_char;
      got.last  = out_last_of_run;
      if (tokens_due.size() == 0) begin
        note_failure({"unexpected token: ", tok_text(got)});
      end else begin
        want = tokens_due.pop_front();
        if (got !== want)
          note_failure({"token mismatch: expected ", tok_text(want), " / actual ",
                        tok_text(got)});
      end
    end
  end

  // Pop side: random idling, plus a counted hold-off on request
  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (pop_hold_left > 0) begin
        out_pop <= 1'b0;
        pop_hold_left--;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  // Offer one transaction until the block takes it, then predict its tokens
  task automatic send_byte(input logic [7:0] ch, input logic eos);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push          <= 1'b1;
    in_char_code     <= ch;
    in_end_of_source <= eos;
    forever begin
      @(posedge clk);
      if (!in_full) break;
    end
    lex_step(ch, eos);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  function automatic logic [7:0] pick_punct(input int sel);
    case (sel % 7)
      0:       return sts_pkg::CH_LPAREN;
      1:       return sts_pkg::CH_RPAREN;
      2:       return sts_pkg::CH_LBRACE;
      3:       return sts_pkg::CH_RBRACE;
      4:       return sts_pkg::CH_SEMI;
      5:       return sts_pkg::CH_EQUAL;
      default: return sts_pkg::CH_PLUS;
    endcase
  endfunction

  function automatic logic [7:0] rand_word_char(input bit digits_ok);
    int r;
    r = $urandom_range(digits_ok ? 62 : 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return sts_pkg::CH_UNDER;
    return 8'("0" + r - 53);
  endfunction

  // One random lexical unit, mostly well formed, sometimes followed by a separator
  task automatic send_random_token();
    int n;
    int pick;
    pick = $urandom_range(99);
    if (pick < 12) begin
      if ($urandom_range(1)) send_text("int");
      else send_text("return");
    end else if (pick < 22) begin
      case ($urandom_range(9))
        0: send_text("i");
        1: send_text("in");
        2: send_text("intx");
        3: send_text("re");
        4: send_text("retur");
        5: send_text("returns");
        6: send_text("int_");
        7: send_text("return9");
        8: send_text("rint");
        default: send_text("iint");
      endcase
    end else if (pick < 40) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
      send_byte(rand_word_char(1'b0), 1'b0);
      repeat (n - 1) send_byte(rand_word_char(1'b1), 1'b0);
    end else if (pick < 58) begin
      n = ($urandom_range(5) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 4);
      repeat (n) send_byte(8'("0" + $urandom_range(9)), 1'b0);
    end else if (pick < 75) begin
      send_byte(pick_punct($urandom_range(6)), 1'b0);
    end else if (pick < 82) begin
      send_byte($urandom_range(1) ? sts_pkg::CH_NL : sts_pkg::CH_TAB, 1'b0);
    end else if (pick < 96) begin
      send_byte(8'($urandom_range(255)), 1'b0);
    end else begin
      send_byte(8'($urandom_range(255)), 1'b1);
    end
    case ($urandom_range(5))
      0: send_byte(sts_pkg::CH_SPACE, 1'b0);
      1: send_byte(sts_pkg::CH_NL, 1'b0);
      2: send_byte(sts_pkg::CH_CR, 1'b0);
      default: ;
    endcase
  endtask

  // Every token kind, whitespace, extreme bytes and an end marker with a byte
  task automatic test_directed();
    send_text("int return(){};=+9_Z\n\r\t");
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // Numbers past 32 bits, a long word and an end marker after a pending word
  task automatic test_overflow();
    send_text("98765432109876;");
    send_text("4294967295 4294967296\n");
    send_text("abcdefghij");
    send_byte(8'h80, 1'b0);
    send_text("retu");
    send_byte(8'($urandom_range(255)), 1'b1);
  endtask

  // Stall the pop side long enough for the block to fill and push back
  task automatic test_backpressure();
    send_idle_pct = 0;
    pop_hold_left = 150;
    for (int i = 0; i < 40; i++) send_byte(pick_punct(i), 1'b0);
    send_byte(8'h00, 1'b1);
    send_idle_pct = 18;
  endtask

  // Random token streams: a stretch without idling, then idling on both sides
  task automatic test_random();
    int first;
    first = items_sent;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (items_sent - first < 300) send_random_token();
    send_idle_pct = 18;
    recv_idle_pct = 18;
    while (items_sent - first < 1330) send_random_token();
    send_byte(8'($urandom_range(255)), 1'b1);
  endtask

  initial begin
    int guard;
    rst_n            = 1'b0;
    in_push          = 1'b0;
    in_char_code     = 8'd0;
    in_end_of_source = 1'b0;
    fail_count       = 0;
    items_sent       = 0;
    send_idle_pct    = 18;
    recv_idle_pct    = 18;
    pop_hold_left    = 0;
    held_valid       = 1'b0;
    reset_state();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_backpressure();
    test_random();
    test_overflow();

    @(negedge clk);
    in_push <= 1'b0;

    // Drain outstanding tokens, then watch for strays
    guard = 0;
    while (tokens_due.size() > 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (tokens_due.size() > 0)
      note_failure($sformatf("%0d predicted tokens never arrived", tokens_due.size()));

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
